// ===== hdl/laf_pkg.sv =====
// ----------------------------------------------------------------------------
// laf_pkg
// Shared widths, reset values and control types for the location adjacency
// filter.
// ----------------------------------------------------------------------------
package laf_pkg;

   localparam int LOC_W          = 31;
   localparam int DEPTH_DEFAULT  = 4;
   localparam logic [LOC_W-1:0] WINDOW_RESET = 31'd1024;

   typedef logic [LOC_W-1:0] loc_type;

   // Per-strand control from the top level
   typedef struct packed {
      logic step;    // shift the stage-one location into this history
      logic clear;   // end of stream: empty the history
   } strand_ctrl_type;

   // Per-strand test outcome back to the top level
   typedef struct packed {
      logic    hit;     // full history and oldest entry is inside the window
      loc_type oldest;
   } strand_stat_type;

endpackage

// ===== hdl/laf_strand.sv =====
// ----------------------------------------------------------------------------
// laf_strand
// Shift history and fill counter for one strand, with the window test against
// the oldest held location.
// ----------------------------------------------------------------------------
module laf_strand #(
   parameter int HISTORY_DEPTH = laf_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  laf_pkg::strand_ctrl_type ctrl,
   input  laf_pkg::loc_type         location,
   input  laf_pkg::loc_type         window_range,
   output laf_pkg::strand_stat_type stat
);
   import laf_pkg::*;

   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [FILL_W-1:0] FULL_COUNT = FILL_W'(HISTORY_DEPTH);

   loc_type           hist_ff [HISTORY_DEPTH];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              full;
   loc_type           diff;

   assign full = (fill_ff == FULL_COUNT);
   // Modulo 2^31 difference falls out of the 31-bit subtract
   assign diff = location - hist_ff[0];

   assign stat.hit    = full && (diff < window_range);
   assign stat.oldest = hist_ff[0];

   always_comb begin
      fill_in = fill_ff;
      if (ctrl.clear) begin
         fill_in = '0;
      end else if (ctrl.step && !full) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Entries are only read once the history is full, so no clearing is needed
   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         for (int j = 0; j < HISTORY_DEPTH - 1; j++) begin
            hist_ff[j] <= hist_ff[j+1];
         end
         hist_ff[HISTORY_DEPTH-1] <= location;
      end
   end

endmodule

// ===== hdl/location_adjacency_filter_core.sv =====
// ----------------------------------------------------------------------------
// location_adjacency_filter_core
// Per-strand adjacency filter over a sorted stream of seed locations.
// ----------------------------------------------------------------------------
// Every request passes through the input register and then the response
// register, and one request is taken in every cycle while responses are
// taken. The rate is set by the history shift and window compare of each
// strand, which both finish in the cycle an item leaves the input register.
// A request whose strand history is full and whose location lies less than
// window_range (modulo 2^31) past the oldest held location returns that
// oldest location; an end-of-stream request returns an end marker with a
// zero location and empties both histories. Other requests return nothing.
// csr_wr_data loads window_range (reset 1024); the user must write it only
// while idle, as the block itself does not enforce this.
module location_adjacency_filter_core #(
   parameter int HISTORY_DEPTH = laf_pkg::DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  laf_pkg::loc_type        req_location,
   input  logic                    req_strand,
   input  logic                    req_is_end,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output laf_pkg::loc_type        rsp_kept_location,
   output logic                    rsp_end_marker,
   // configuration
   input  logic                    csr_wr_en,
   input  laf_pkg::loc_type        csr_wr_data
);
   import laf_pkg::*;

   // window register
   loc_type window_ff;

   // input register (stage one)
   logic    s1_valid_ff;
   loc_type s1_location_ff;
   logic    s1_strand_ff;
   logic    s1_is_end_ff;

   // response register
   logic    rsp_valid_ff;
   loc_type rsp_kept_location_ff;
   logic    rsp_end_marker_ff;

   logic            advance;     // stage-one item is processed this cycle
   logic            rsp_free;
   strand_ctrl_type ctrl_one;
   strand_ctrl_type ctrl_two;
   strand_stat_type stat_one;
   strand_stat_type stat_two;
   strand_stat_type stat_sel;

   // The response register is free when empty or being drained this cycle.
   // Stage one waits on it even for items that make no result; that keeps
   // the control simple and costs nothing while the sink keeps up.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || advance;

   // Strand bit one selects history one, zero selects history two
   assign ctrl_one.step  = advance && !s1_is_end_ff && s1_strand_ff;
   assign ctrl_one.clear = advance && s1_is_end_ff;
   assign ctrl_two.step  = advance && !s1_is_end_ff && !s1_strand_ff;
   assign ctrl_two.clear = advance && s1_is_end_ff;

   laf_strand #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_strand_one (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl_one),
      .location     (s1_location_ff),
      .window_range (window_ff),
      .stat         (stat_one)
   );

   laf_strand #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_strand_two (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl_two),
      .location     (s1_location_ff),
      .window_range (window_ff),
      .stat         (stat_two)
   );

   assign stat_sel = s1_strand_ff ? stat_one : stat_two;

   // Window register: no handshake, written whenever the enable is high
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         window_ff <= csr_wr_data;
      end
   end

   // Stage one control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Stage one payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_location_ff <= req_location;
         s1_strand_ff   <= req_strand;
         s1_is_end_ff   <= req_is_end;
      end
   end

   // Response control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_is_end_ff || stat_sel.hit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (advance) begin
         if (s1_is_end_ff) begin
            rsp_kept_location_ff <= '0;
            rsp_end_marker_ff    <= 1'b1;
         end else begin
            rsp_kept_location_ff <= stat_sel.oldest;
            rsp_end_marker_ff    <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kept_location = rsp_kept_location_ff;
   assign rsp_end_marker    = rsp_end_marker_ff;

   // An end item leaving stage one always makes an end-marker response
   a_end_response: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_is_end_ff) |=> (rsp_valid && rsp_end_marker))
      else $error("end item produced no end marker");

   // End-marker responses carry a zero location
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_marker) |-> (rsp_kept_location == '0))
      else $error("end marker with nonzero location");

   // A response still waiting must not be overwritten by stage one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !advance)
      else $error("stage one advanced over a stalled response");

endmodule

// ===== tb/sv/tb_location_adjacency_filter_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_location_adjacency_filter_core
// Self-checking bench for the per-strand location adjacency filter. A driver
// feeds seed locations from a queue, and a scoreboard keeps its own model of
// both strand histories. Each response is compared field by field with the
// oldest predicted survivor or end marker. Both channels idle at random, and
// window_range is swept across its extremes between quiet phases.
// ----------------------------------------------------------------------------
module tb_location_adjacency_filter_core;
   import laf_pkg::*;

   localparam int DEPTH         = DEPTH_DEFAULT;
   localparam int PHASES        = 7;
   localparam int PHASE_SEEDS   = 160;
   // Pause after the last result before touching window_range.
   localparam int SETTLE_CYCLES = 6;
   // Worst legal quiet stretch is made of gap, stall and latency, plus a
   // settle pause and a window write between phases.
   localparam int QUIET_LIMIT   = 1000;

   typedef struct packed {
      loc_type location;
      logic    strand;
      logic    is_end;
   } seed_type;

   typedef struct packed {
      loc_type kept;
      logic    end_marker;
   } survivor_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   loc_type req_location = '0;
   logic    req_strand = 1'b0;
   logic    req_is_end = 1'b0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   loc_type rsp_kept_location;
   logic    rsp_end_marker;
   logic    csr_wr_en = 1'b0;
   loc_type csr_wr_data = '0;

   // Scoreboard copy of the block state. Index 1 is history one (strand 1),
   // index 0 is history two (strand 0), so the strand bit selects directly.
   loc_type   history [2][DEPTH];
   int        fill [2];
   loc_type   window_span = WINDOW_RESET;

   seed_type     seed_queue[$];      // seeds waiting for the driver
   survivor_type survivor_queue[$];  // predicted responses, oldest first
   seed_type     cur_seed;
   logic      send_busy = 1'b0;   // payload on the bus, transfer pending
   int        send_gap = 0;
   int        take_stall = 0;
   logic      send_idle = 1'b1;
   logic      recv_idle = 1'b1;
   int        fail_count = 0;
   int        quiet_cycles = 0;
   loc_type   run_loc [2];        // running sorted position per strand

   location_adjacency_filter_core #(
      .HISTORY_DEPTH(DEPTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_location     (req_location),
      .req_strand       (req_strand),
      .req_is_end       (req_is_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kept_location(rsp_kept_location),
      .rsp_end_marker   (rsp_end_marker),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Predict what one accepted seed produces and advance the model state.
   task automatic filter_seed(input seed_type s);
      loc_type      oldest;
      loc_type      delta;
      logic         hit;
      survivor_type r;
      int           j;
      if (s.is_end) begin
         // End of stream: marker out, both strands start over empty.
         for (j = 0; j < DEPTH; j++) begin
            history[0][j] = '0;
            history[1][j] = '0;
         end
         fill[0] = 0;
         fill[1] = 0;
         r.kept = '0;
         r.end_marker = 1'b1;
         survivor_queue.push_back(r);
         return;
      end
      hit = 1'b0;
      oldest = history[s.strand][0];
      if (fill[s.strand] >= DEPTH) begin
         // 31-bit subtraction wraps mod 2^31, so an out-of-order seed
         // gives a huge distance that only a window near the full range passes.
         delta = s.location - oldest;
         hit = (delta < window_span);
      end else begin
         fill[s.strand]++;
      end
      for (j = 0; j + 1 < DEPTH; j++) begin
         history[s.strand][j] = history[s.strand][j+1];
      end
      history[s.strand][DEPTH-1] = s.location;
      if (hit) begin
         r.kept = oldest;
         r.end_marker = 1'b0;
         survivor_queue.push_back(r);
      end
   endtask

   task automatic queue_seed(input loc_type loc, input logic strand, input logic is_end);
      seed_type s;
      s.location = loc;
      s.strand = strand;
      s.is_end = is_end;
      seed_queue.push_back(s);
   endtask

   // Mostly sorted per-strand runs whose steps are sized so four steps land
   // around the window edge; the rest is fresh bases, noise and end items.
   task automatic queue_stream(input int count);
      int unsigned step_span;
      int unsigned pick;
      int unsigned step;
      logic        s;
      int          i;
      step_span = (window_span == 0) ? 64 : int'(window_span >> 1);
      if (step_span == 0) begin
         step_span = 1;
      end
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         s = 1'($urandom_range(0, 1));
         if (pick < 3) begin
            // location and strand are don't-care on an end item
            queue_seed(loc_type'($urandom), s, 1'b1);
         end else if (pick < 9) begin
            queue_seed(loc_type'($urandom), s, 1'b0);
         end else begin
            if (pick < 12) begin
               run_loc[s] = loc_type'($urandom);
            end
            step = $urandom_range(0, step_span);
            run_loc[s] = run_loc[s] + loc_type'(step);
            queue_seed(run_loc[s], s, 1'b0);
         end
      end
   endtask

   // Quiet point: nothing waiting, nothing on the bus, nothing owed.
   task automatic wait_idle();
      while (seed_queue.size() != 0 || send_busy || survivor_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input loc_type value);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      window_span = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Request driver: one payload at a time, optional gap before each.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_busy = 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            filter_seed(cur_seed);
            send_busy = 1'b0;
            send_gap = send_idle ? $urandom_range(0, 4) : 0;
         end
         if (!send_busy) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (seed_queue.size() != 0) begin
               cur_seed = seed_queue.pop_front();
               req_location <= cur_seed.location;
               req_strand <= cur_seed.strand;
               req_is_end <= cur_seed.is_end;
               send_busy = 1'b1;
            end
         end
         // Single update per edge, so back-to-back transfers keep valid high.
         req_valid <= send_busy;
      end
   end

   // Response monitor: check each transfer, then maybe stall for a while.
   always @(posedge clock) begin
      survivor_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         take_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (survivor_queue.size() == 0) begin
               $error("unexpected response: kept_location %0h end_marker %0b",
                      rsp_kept_location, rsp_end_marker);
               fail_count++;
            end else begin
               want = survivor_queue.pop_front();
               if (rsp_kept_location !== want.kept) begin
                  $error("kept_location: expected %0h, actual %0h",
                         want.kept, rsp_kept_location);
                  fail_count++;
               end
               if (rsp_end_marker !== want.end_marker) begin
                  $error("end_marker: expected %0b, actual %0b",
                         want.end_marker, rsp_end_marker);
                  fail_count++;
               end
            end
            take_stall = recv_idle ? $urandom_range(0, 4) : 0;
         end else if (take_stall > 0) begin
            take_stall--;
         end
         rsp_ready <= (take_stall == 0);
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      loc_type window_plan [PHASES];
      int      phase;
      int      j;
      for (j = 0; j < DEPTH; j++) begin
         history[0][j] = '0;
         history[1][j] = '0;
      end
      fill[0] = 0;
      fill[1] = 0;
      run_loc[0] = loc_type'($urandom);
      run_loc[1] = loc_type'($urandom);

      // Window sweep: zero (nothing passes), smallest, full range, reset
      // value, a moderate random one, an unconstrained random one, tiny.
      window_plan[0] = '0;
      window_plan[1] = 31'd1;
      window_plan[2] = 31'h7FFF_FFFF;
      window_plan[3] = WINDOW_RESET;
      window_plan[4] = loc_type'($urandom_range(2, 1 << 20));
      window_plan[5] = loc_type'($urandom);
      window_plan[6] = 31'd16;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed seeds under the reset window of 1024.
      // Strand 1 fills, then one inside and one outside the window.
      queue_seed(31'd100, 1'b1, 1'b0);
      queue_seed(31'd200, 1'b1, 1'b0);
      queue_seed(31'd300, 1'b1, 1'b0);
      queue_seed(31'd400, 1'b1, 1'b0);
      queue_seed(31'd500, 1'b1, 1'b0);
      queue_seed(31'd2000, 1'b1, 1'b0);
      // Strand 0 wraps through the top of the range: passes across the
      // wrap, then an out-of-order seed gives a wrapped, huge distance.
      queue_seed(31'h7FFF_FFF0, 1'b0, 1'b0);
      queue_seed(31'h7FFF_FFFF, 1'b0, 1'b0);
      queue_seed(31'd0, 1'b0, 1'b0);
      queue_seed(31'd1, 1'b0, 1'b0);
      queue_seed(31'h10, 1'b0, 1'b0);
      queue_seed(31'h7FFF_FF00, 1'b0, 1'b0);
      // End item with junk in the ignored fields.
      queue_seed(31'h7FFF_FFFF, 1'b1, 1'b1);
      // Refill after the clear; distance of window-1 passes, window does not.
      queue_seed(31'd10, 1'b1, 1'b0);
      queue_seed(31'd11, 1'b1, 1'b0);
      queue_seed(31'd12, 1'b1, 1'b0);
      queue_seed(31'd13, 1'b1, 1'b0);
      queue_seed(31'd1033, 1'b1, 1'b0);
      queue_seed(31'd1035, 1'b1, 1'b0);
      // Partly filled strand cut short by an end item.
      queue_seed(31'd7, 1'b0, 1'b0);
      queue_seed(31'd8, 1'b0, 1'b0);
      queue_seed(31'd9, 1'b0, 1'b0);
      queue_seed(31'd0, 1'b0, 1'b1);

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         // Rotate idling: both sides, none, sender only, receiver only.
         send_idle = (phase % 4 == 0) || (phase % 4 == 2);
         recv_idle = (phase % 4 == 0) || (phase % 4 == 3);
         write_window(window_plan[phase]);
         queue_stream(PHASE_SEEDS);
      end
      wait_idle();

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
